FILE: hdl/c8afr_pkg.sv
// Shared types, codes and the CRC-8 byte update for the address frame receiver.
package c8afr_pkg;

    localparam int FRAME_LEN   = 9;
    localparam int STORE_DEPTH = FRAME_LEN - 1;
    localparam int STORE_IDX_W = $clog2(STORE_DEPTH);
    localparam int CNT_W       = 4;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'hA1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_ADDR_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_ADDR_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BCAST_ADDR_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BCAST_ADDR_LOW  = 3'd4;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_RECEIVING = 3'd1,
        ST_TIMEOUT   = 3'd2,
        ST_CRC_ERROR = 3'd3,
        ST_FOR_US    = 3'd4,
        ST_OTHER     = 3'd5
    } status_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] addr_high;
        logic [7:0] addr_low;
        logic [7:0] func_code;
        logic [7:0] data0;
        logic [7:0] data1;
        logic [7:0] data2;
        logic [7:0] data3;
        logic [7:0] data4;
        logic [7:0] crc_byte;
    } result_t;

    // Reflected CRC-8: eight shift-right steps with a conditional polynomial XOR.
    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: hdl/crc8_address_frame_receiver.sv
// Top level of the CRC-8 checked nine-byte address frame receiver.
//
// The block takes one transfer per clock on the input channel while s_ready is high: either
// a received bus byte (s_op low) or a timer tick (s_op high), and gives exactly one
// registered result transfer for each. Bytes build a nine-byte frame of two address bytes,
// a function byte, five data bytes and a check byte; a reflected CRC-8 (initial value 0xFF,
// polynomial 0xA1) runs over the first eight. Every byte reloads the inter-byte timeout from
// the timeout_ticks register, each tick during a partial frame counts it down, and the
// partial frame is dropped with status "timeout" when it reaches zero. On the ninth byte the
// result carries the frame fields and the status "crc error", "frame for us" (own or
// broadcast address) or "other destination"; for every other result the frame fields are
// zero. While the output stage does not fill, the sustained rate is one item per cycle; the
// per-item work, the CRC byte update among it, is combinational between the frame state
// registers and the result register. A two-entry output stage (result register plus skid
// register) lets the block keep accepting while a finished result waits for m_ready; s_ready
// falls only once both entries are full. Configuration writes are taken on any cycle with
// cfg_wr_en high and should be made while the block is idle. No clearing pass follows reset.
module crc8_address_frame_receiver #(
    parameter int TIMEOUT_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [c8afr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [c8afr_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_op,
    input  logic [7:0]                          s_rx_byte,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [2:0]                          m_status,
    output logic [7:0]                          m_addr_high,
    output logic [7:0]                          m_addr_low,
    output logic [7:0]                          m_func_code,
    output logic [7:0]                          m_data0,
    output logic [7:0]                          m_data1,
    output logic [7:0]                          m_data2,
    output logic [7:0]                          m_data3,
    output logic [7:0]                          m_data4,
    output logic [7:0]                          m_crc_byte
);

    // Configuration registers.
    logic [c8afr_pkg::CFG_DATA_W-1:0] timeout_ticks_reg;
    logic [7:0]                       node_addr_high_reg;
    logic [7:0]                       node_addr_low_reg;
    logic [7:0]                       bcast_addr_high_reg;
    logic [7:0]                       bcast_addr_low_reg;

    // Frame state.
    logic [7:0]                       store_reg [c8afr_pkg::STORE_DEPTH];
    logic [c8afr_pkg::CNT_W-1:0]      byte_cnt_reg, byte_cnt_next;
    logic [7:0]                       crc_reg, crc_next;
    logic [TIMEOUT_WIDTH-1:0]         timeout_left_reg, timeout_left_next;
    logic [TIMEOUT_WIDTH-1:0]         tick_left;
    logic                             store_we;
    logic                             addr_match;

    // Output stage: result register and skid register.
    c8afr_pkg::result_t               out_reg, out_next;
    c8afr_pkg::result_t               skid_reg, skid_next;
    logic                             out_valid_reg, out_valid_next;
    logic                             skid_valid_reg, skid_valid_next;
    c8afr_pkg::result_t               res;

    logic                             s_accept;
    logic                             m_pop;

    assign s_ready  = ~skid_valid_reg;
    assign s_accept = s_valid & s_ready;
    assign m_pop    = out_valid_reg & m_ready;

    // Configuration writes; indexes outside the register list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_ticks_reg   <= 16'd100;
            node_addr_high_reg  <= 8'd1;
            node_addr_low_reg   <= 8'd1;
            bcast_addr_high_reg <= 8'd255;
            bcast_addr_low_reg  <= 8'd255;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                c8afr_pkg::REG_TIMEOUT_TICKS:   timeout_ticks_reg   <= cfg_wdata;
                c8afr_pkg::REG_NODE_ADDR_HIGH:  node_addr_high_reg  <= cfg_wdata[7:0];
                c8afr_pkg::REG_NODE_ADDR_LOW:   node_addr_low_reg   <= cfg_wdata[7:0];
                c8afr_pkg::REG_BCAST_ADDR_HIGH: bcast_addr_high_reg <= cfg_wdata[7:0];
                c8afr_pkg::REG_BCAST_ADDR_LOW:  bcast_addr_low_reg  <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // The decremented timeout saturates at zero.
    assign tick_left = (timeout_left_reg != '0) ?
                       (timeout_left_reg - TIMEOUT_WIDTH'(1)) : '0;

    // Either the own or the broadcast address counts as a match.
    assign addr_match = ((store_reg[0] == node_addr_high_reg) &&
                         (store_reg[1] == node_addr_low_reg)) ||
                        ((store_reg[0] == bcast_addr_high_reg) &&
                         (store_reg[1] == bcast_addr_low_reg));

    // Per-item work: update the frame state and form the result of the accepted transfer.
    // The ninth byte is not stored; it is compared with the CRC and reported directly.
    always_comb begin
        byte_cnt_next     = byte_cnt_reg;
        crc_next          = crc_reg;
        timeout_left_next = timeout_left_reg;
        store_we          = 1'b0;
        res               = '0;
        res.status        = c8afr_pkg::ST_IDLE;

        if (s_accept) begin
            if (s_op == c8afr_pkg::OP_TICK) begin
                if (byte_cnt_reg != '0) begin
                    timeout_left_next = tick_left;
                    if (tick_left == '0) begin
                        byte_cnt_next = '0;
                        crc_next      = c8afr_pkg::CRC_INIT;
                        res.status    = c8afr_pkg::ST_TIMEOUT;
                    end else begin
                        res.status    = c8afr_pkg::ST_RECEIVING;
                    end
                end
            end else begin
                timeout_left_next = TIMEOUT_WIDTH'(timeout_ticks_reg);
                if (byte_cnt_reg == c8afr_pkg::CNT_W'(c8afr_pkg::FRAME_LEN - 1)) begin
                    if (s_rx_byte != crc_reg) begin
                        res.status = c8afr_pkg::ST_CRC_ERROR;
                    end else if (addr_match) begin
                        res.status = c8afr_pkg::ST_FOR_US;
                    end else begin
                        res.status = c8afr_pkg::ST_OTHER;
                    end
                    res.addr_high = store_reg[0];
                    res.addr_low  = store_reg[1];
                    res.func_code = store_reg[2];
                    res.data0     = store_reg[3];
                    res.data1     = store_reg[4];
                    res.data2     = store_reg[5];
                    res.data3     = store_reg[6];
                    res.data4     = store_reg[7];
                    res.crc_byte  = s_rx_byte;
                    byte_cnt_next = '0;
                    crc_next      = c8afr_pkg::CRC_INIT;
                end else begin
                    store_we      = 1'b1;
                    crc_next      = c8afr_pkg::crc_feed(crc_reg, s_rx_byte);
                    byte_cnt_next = byte_cnt_reg + c8afr_pkg::CNT_W'(1);
                    res.status    = c8afr_pkg::ST_RECEIVING;
                end
            end
        end
    end

    // Output stage: a new result goes to the result register when it is free or being
    // emptied, otherwise it is parked in the skid register.
    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (m_pop || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next        = res;
                out_valid_next  = s_accept;
            end
        end else if (s_accept) begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_cnt_reg     <= '0;
            crc_reg          <= c8afr_pkg::CRC_INIT;
            timeout_left_reg <= '0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end else begin
            byte_cnt_reg     <= byte_cnt_next;
            crc_reg          <= crc_next;
            timeout_left_reg <= timeout_left_next;
            out_valid_reg    <= out_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
        if (store_we) begin
            store_reg[byte_cnt_reg[c8afr_pkg::STORE_IDX_W-1:0]] <= s_rx_byte;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_status    = out_reg.status;
    assign m_addr_high = out_reg.addr_high;
    assign m_addr_low  = out_reg.addr_low;
    assign m_func_code = out_reg.func_code;
    assign m_data0     = out_reg.data0;
    assign m_data1     = out_reg.data1;
    assign m_data2     = out_reg.data2;
    assign m_data3     = out_reg.data3;
    assign m_data4     = out_reg.data4;
    assign m_crc_byte  = out_reg.crc_byte;

endmodule

FILE: hdl/c8afr_checker.sv
// Port-level checker for the address frame receiver, with its bind statement.
module c8afr_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [2:0]                       m_status,
    input logic [7:0]                       m_addr_high,
    input logic [7:0]                       m_addr_low,
    input logic [7:0]                       m_func_code,
    input logic [7:0]                       m_data0,
    input logic [7:0]                       m_data1,
    input logic [7:0]                       m_data2,
    input logic [7:0]                       m_data3,
    input logic [7:0]                       m_data4,
    input logic [7:0]                       m_crc_byte
);

    // A stalled result keeps its status.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result changed while stalled");

    // The input side only stalls when a result is waiting.
    a_stall_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no pending result");

    // Reset empties the output stage.
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present after reset");

    // Results without a finished frame carry zero frame fields.
    a_no_frame_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == c8afr_pkg::ST_IDLE || m_status == c8afr_pkg::ST_RECEIVING ||
                    m_status == c8afr_pkg::ST_TIMEOUT)
        |-> (m_addr_high == 8'd0) && (m_addr_low == 8'd0) && (m_func_code == 8'd0) &&
            (m_data0 == 8'd0) && (m_data1 == 8'd0) && (m_data2 == 8'd0) &&
            (m_data3 == 8'd0) && (m_data4 == 8'd0) && (m_crc_byte == 8'd0))
        else $error("frame fields set without a finished frame");

    // Status codes stay within the defined set.
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= c8afr_pkg::ST_OTHER)
        else $error("undefined status code");

endmodule

bind crc8_address_frame_receiver c8afr_checker u_c8afr_checker (.*);
